/* src/dhfd_pkg.sv */
`timescale 1ns / 1ps

package dhfd_pkg;

  // framing bytes
  localparam logic [7:0] HDR_BYTE = 8'h68;
  localparam logic [7:0] END_BYTE = 8'h16;
  localparam logic [7:0] ZERO_BYTE = 8'h00;

  // hard ceiling on the payload byte count
  localparam logic [10:0] MAX_PAYLOAD = 11'd1024;

  // configuration register indexes
  localparam logic REG_PARSE_ENABLE = 1'b0;
  localparam logic REG_MAX_PAYLOAD  = 1'b1;

  // result kinds
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // frame status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_CSUM_ERR = 3'd1;
  localparam logic [2:0] ST_BAD_END  = 3'd2;
  localparam logic [2:0] ST_BAD_LEN  = 3'd3;
  localparam logic [2:0] ST_BAD_HDR2 = 3'd4;

  // one result word from the parser
  typedef struct packed {
    logic        valid;
    logic        kind;
    logic [7:0]  data;
    logic [15:0] ctl;
    logic [15:0] adr;
    logic [2:0]  status;
  } res_t;

endpackage

/* src/dhfd_parser.sv */
`timescale 1ns / 1ps

module dhfd_parser import dhfd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [7:0]  rx_byte,
  input  logic        parse_enable,
  input  logic [10:0] max_payload,
  output res_t        res
);

  // parse phases
  localparam logic [3:0] PH_HUNT   = 4'd0;
  localparam logic [3:0] PH_LEN_HI = 4'd1;
  localparam logic [3:0] PH_LEN_LO = 4'd2;
  localparam logic [3:0] PH_HDR2   = 4'd3;
  localparam logic [3:0] PH_CTL_HI = 4'd4;
  localparam logic [3:0] PH_CTL_LO = 4'd5;
  localparam logic [3:0] PH_ADR_HI = 4'd6;
  localparam logic [3:0] PH_ADR_LO = 4'd7;
  localparam logic [3:0] PH_DATA   = 4'd8;
  localparam logic [3:0] PH_CSUM   = 4'd9;
  localparam logic [3:0] PH_END    = 4'd10;

  logic [3:0]  phase_r, phase_nxt;
  logic [7:0]  len_hi_r, len_hi_nxt;
  logic [10:0] left_r, left_nxt;
  logic [15:0] ctl_r, ctl_nxt;
  logic [15:0] adr_r, adr_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic        csum_ok_r, csum_ok_nxt;

  logic [10:0] limit;
  logic [15:0] len;
  logic [15:0] count;
  logic        len_bad;
  logic [7:0]  sum_add;

  // length check against the tighter of register and ceiling
  assign limit   = (max_payload < MAX_PAYLOAD) ? max_payload : MAX_PAYLOAD;
  assign len     = {len_hi_r, rx_byte};
  assign count   = len - 16'd4;
  assign len_bad = (len < 16'd4) || (count > {5'd0, limit});
  assign sum_add = sum_r + rx_byte;

  // next state and result for one byte
  always_comb begin
    phase_nxt   = phase_r;
    len_hi_nxt  = len_hi_r;
    left_nxt    = left_r;
    ctl_nxt     = ctl_r;
    adr_nxt     = adr_r;
    sum_nxt     = sum_r;
    csum_ok_nxt = csum_ok_r;
    res         = '0;

    if (!parse_enable) begin
      // raw passthrough, any partial frame is dropped
      phase_nxt   = PH_HUNT;
      left_nxt    = '0;
      sum_nxt     = '0;
      csum_ok_nxt = 1'b0;
      res.valid   = 1'b1;
      res.kind    = KIND_DATA;
      res.data    = rx_byte;
    end else begin
      case (phase_r)
        PH_LEN_HI: begin
          len_hi_nxt = rx_byte;
          phase_nxt  = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          if (len_bad) begin
            phase_nxt  = PH_HUNT;
            left_nxt   = '0;
            sum_nxt    = '0;
            res.valid  = 1'b1;
            res.kind   = KIND_END;
            res.status = ST_BAD_LEN;
          end else begin
            left_nxt  = count[10:0];
            phase_nxt = PH_HDR2;
          end
        end
        PH_HDR2: begin
          if (rx_byte != HDR_BYTE) begin
            phase_nxt  = PH_HUNT;
            left_nxt   = '0;
            sum_nxt    = '0;
            res.valid  = 1'b1;
            res.kind   = KIND_END;
            res.status = ST_BAD_HDR2;
          end else begin
            sum_nxt   = '0;
            phase_nxt = PH_CTL_HI;
          end
        end
        PH_CTL_HI: begin
          ctl_nxt   = {rx_byte, ZERO_BYTE};
          sum_nxt   = sum_add;
          phase_nxt = PH_CTL_LO;
        end
        PH_CTL_LO: begin
          ctl_nxt   = {ctl_r[15:8], rx_byte};
          sum_nxt   = sum_add;
          phase_nxt = PH_ADR_HI;
        end
        PH_ADR_HI: begin
          adr_nxt   = {rx_byte, ZERO_BYTE};
          sum_nxt   = sum_add;
          phase_nxt = PH_ADR_LO;
        end
        PH_ADR_LO: begin
          adr_nxt   = {adr_r[15:8], rx_byte};
          sum_nxt   = sum_add;
          phase_nxt = (left_r == '0) ? PH_CSUM : PH_DATA;
        end
        PH_DATA: begin
          sum_nxt = sum_add;
          if (left_r != '0) begin
            left_nxt = left_r - 11'd1;
          end
          if (left_r <= 11'd1) begin
            phase_nxt = PH_CSUM;
          end
          res.valid = 1'b1;
          res.kind  = KIND_DATA;
          res.data  = rx_byte;
          res.ctl   = ctl_r;
          res.adr   = adr_r;
        end
        PH_CSUM: begin
          csum_ok_nxt = (rx_byte == ~sum_r);
          phase_nxt   = PH_END;
        end
        PH_END: begin
          res.valid = 1'b1;
          res.kind  = KIND_END;
          res.ctl   = ctl_r;
          res.adr   = adr_r;
          if (rx_byte != END_BYTE) begin
            res.status = ST_BAD_END;
          end else begin
            res.status = csum_ok_r ? ST_OK : ST_CSUM_ERR;
          end
          phase_nxt   = PH_HUNT;
          left_nxt    = '0;
          sum_nxt     = '0;
          csum_ok_nxt = 1'b0;
        end
        default: begin
          // hunting, also any unused phase code
          if (rx_byte == HDR_BYTE) begin
            phase_nxt   = PH_LEN_HI;
            left_nxt    = '0;
            sum_nxt     = '0;
            csum_ok_nxt = 1'b0;
          end else begin
            phase_nxt = PH_HUNT;
          end
        end
      endcase
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      left_r    <= '0;
      sum_r     <= '0;
      csum_ok_r <= 1'b0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      left_r    <= left_nxt;
      sum_r     <= sum_nxt;
      csum_ok_r <= csum_ok_nxt;
    end
  end

  // frame fields, always loaded before use
  always_ff @(posedge clk) begin
    if (step) begin
      len_hi_r <= len_hi_nxt;
      ctl_r    <= ctl_nxt;
      adr_r    <= adr_nxt;
    end
  end

endmodule

/* src/dual_header_frame_deframer_unit.sv */
`timescale 1ns / 1ps

// channel   direction  handshake             words
// in_       input      in_valid / in_ready   in_rx_byte
// out_      output     out_valid / out_ready result_kind, data_byte, control_word,
//                                            address_word, frame_status
// cfg_      input      cfg_wr_en             cfg_index, cfg_wdata
//
// one byte per cycle while in_ready is high; each byte updates the parser, and a
// byte that gives a result lands in the output register on the next edge.
// in_ready drops only while a result word sits in the output register and
// out_ready is low; bytes that give no result still wait for that slot.
// synchronous active-low reset: parser hunts for a header, output empty,
// parse_enable = 1, max_payload = 1024.

module dual_header_frame_deframer_unit import dhfd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_result_kind,
  output logic [7:0]  out_data_byte,
  output logic [15:0] out_control_word,
  output logic [15:0] out_address_word,
  output logic [2:0]  out_frame_status,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [10:0] cfg_wdata
);

  logic        parse_enable_r;
  logic [10:0] max_payload_r;
  logic        out_valid_r;
  res_t        out_r;
  res_t        res;
  logic        in_fire;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parse_enable_r <= 1'b1;
      max_payload_r  <= MAX_PAYLOAD;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_PARSE_ENABLE: parse_enable_r <= cfg_wdata[0];
        REG_MAX_PAYLOAD:  max_payload_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  dhfd_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (in_fire),
    .rx_byte      (in_rx_byte),
    .parse_enable (parse_enable_r),
    .max_payload  (max_payload_r),
    .res          (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res.valid) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_kind  = out_r.kind;
  assign out_data_byte    = out_r.data;
  assign out_control_word = out_r.ctl;
  assign out_address_word = out_r.adr;
  assign out_frame_status = out_r.status;

  // passthrough byte shows up next cycle with empty frame fields
  a_passthrough: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !parse_enable_r |=> out_valid_r && out_result_kind == KIND_DATA
      && out_control_word == 16'd0 && out_address_word == 16'd0
      && out_data_byte == $past(in_rx_byte))
    else $error("passthrough word not delivered raw");

  // payload words always carry an ok status
  a_data_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_result_kind == KIND_DATA |-> out_frame_status == ST_OK)
    else $error("payload word with nonzero status");

  // status code stays in the defined range
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_frame_status <= ST_BAD_HDR2)
    else $error("undefined frame status");

  // an empty output slot never stalls the input
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with empty output");

endmodule

/* tb/sv/tb_dual_header_frame_deframer_unit.sv */
`timescale 1ns / 1ps

module tb_dual_header_frame_deframer_unit;
  import dhfd_pkg::*;

  localparam int IDLE_PCT    = 11;
  localparam int STALL_LIMIT = 5000;

  // parser phases as the block walks a frame
  typedef enum logic [3:0] {
    P_HUNT, P_LEN_HI, P_LEN_LO, P_HDR2, P_CTL_HI, P_CTL_LO,
    P_ADR_HI, P_ADR_LO, P_DATA, P_CSUM, P_END
  } parse_phase_t;

  // ways a generated frame can be broken
  typedef enum int {
    FE_NONE, FE_CSUM, FE_END, FE_SHORT, FE_LONG, FE_HDR2
  } frame_err_t;

  // one output word
  typedef struct packed {
    logic        kind;
    logic [7:0]  data;
    logic [15:0] ctl;
    logic [15:0] adr;
    logic [2:0]  status;
  } frame_word_t;

  // tracks parser state and the output words still owed by the block
  class deframe_tracker;
    bit           parse_on;
    logic [10:0]  max_len;
    parse_phase_t phase;
    logic [15:0]  frame_len;
    logic [10:0]  left;
    logic [15:0]  ctl_q;
    logic [15:0]  adr_q;
    logic [7:0]   sum;
    bit           sum_ok;
    frame_word_t  awaited[$];
    int           errors;

    function new();
      parse_on = 1'b1;
      max_len  = MAX_PAYLOAD;
      errors   = 0;
      restart();
    endfunction

    function void restart();
      phase     = P_HUNT;
      frame_len = '0;
      left      = '0;
      ctl_q     = '0;
      adr_q     = '0;
      sum       = '0;
      sum_ok    = 1'b0;
    endfunction

    function void set_reg(logic idx, logic [10:0] v);
      if (idx == REG_PARSE_ENABLE) parse_on = v[0];
      else max_len = v;
    endfunction

    function void owe(logic kind, logic [7:0] data, logic [15:0] ctl,
                      logic [15:0] adr, logic [2:0] status);
      frame_word_t w;
      w = {kind, data, ctl, adr, status};
      awaited.push_back(w);
    endfunction

    // advance the parser by one accepted byte
    function void note_byte(logic [7:0] b);
      logic [10:0] lim;
      logic [15:0] ctl_c;
      logic [15:0] adr_c;
      logic [2:0]  st;
      lim = (max_len < MAX_PAYLOAD) ? max_len : MAX_PAYLOAD;
      if (!parse_on) begin
        restart();
        owe(KIND_DATA, b, 16'h0, 16'h0, ST_OK);
        return;
      end
      case (phase)
        P_LEN_HI: begin
          frame_len = {b, 8'h00};
          phase = P_LEN_LO;
        end
        P_LEN_LO: begin
          frame_len[7:0] = b;
          if (frame_len < 16'd4 || (frame_len - 16'd4) > {5'd0, lim}) begin
            restart();
            owe(KIND_END, 8'h00, 16'h0, 16'h0, ST_BAD_LEN);
          end else begin
            left = 11'(frame_len - 16'd4);
            phase = P_HDR2;
          end
        end
        P_HDR2: begin
          if (b != HDR_BYTE) begin
            restart();
            owe(KIND_END, 8'h00, 16'h0, 16'h0, ST_BAD_HDR2);
          end else begin
            sum = '0;
            phase = P_CTL_HI;
          end
        end
        P_CTL_HI: begin
          ctl_q = {b, 8'h00};
          sum += b;
          phase = P_CTL_LO;
        end
        P_CTL_LO: begin
          ctl_q[7:0] = b;
          sum += b;
          phase = P_ADR_HI;
        end
        P_ADR_HI: begin
          adr_q = {b, 8'h00};
          sum += b;
          phase = P_ADR_LO;
        end
        P_ADR_LO: begin
          adr_q[7:0] = b;
          sum += b;
          phase = (left == 0) ? P_CSUM : P_DATA;
        end
        P_DATA: begin
          sum += b;
          if (left > 0) left--;
          if (left == 0) phase = P_CSUM;
          owe(KIND_DATA, b, ctl_q, adr_q, ST_OK);
        end
        P_CSUM: begin
          sum_ok = (b == ~sum);
          phase = P_END;
        end
        P_END: begin
          ctl_c = ctl_q;
          adr_c = adr_q;
          if (b != END_BYTE) st = ST_BAD_END;
          else st = sum_ok ? ST_OK : ST_CSUM_ERR;
          restart();
          owe(KIND_END, 8'h00, ctl_c, adr_c, st);
        end
        default: begin
          if (b == HDR_BYTE) begin
            restart();
            phase = P_LEN_HI;
          end else begin
            phase = P_HUNT;
          end
        end
      endcase
    endfunction

    // compare one accepted output word with the oldest one owed
    function void check_word(frame_word_t got);
      frame_word_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: unexpected word: expected none, got kind %0d data %h ctl %h adr %h st %0d",
                 $time, got.kind, got.data, got.ctl, got.adr, got.status);
        return;
      end
      want = awaited.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: word mismatch: expected kind %0d data %h ctl %h adr %h st %0d",
                 $time, want.kind, want.data, want.ctl, want.adr, want.status);
        $display("%0t:                got      kind %0d data %h ctl %h adr %h st %0d",
                 $time, got.kind, got.data, got.ctl, got.adr, got.status);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_result_kind;
  logic [7:0]  out_data_byte;
  logic [15:0] out_control_word;
  logic [15:0] out_address_word;
  logic [2:0]  out_frame_status;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_index = 1'b0;
  logic [10:0] cfg_wdata = 11'd0;

  deframe_tracker board;
  bit idle_on = 1'b1;
  int bytes_sent = 0;
  int stall_cycles = 0;

  dual_header_frame_deframer_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_kind (out_result_kind),
    .out_data_byte   (out_data_byte),
    .out_control_word(out_control_word),
    .out_address_word(out_address_word),
    .out_frame_status(out_frame_status),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result side: check accepted words, drop ready at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready)
        board.check_word({out_result_kind, out_data_byte, out_control_word,
                          out_address_word, out_frame_status});
      out_ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb_dual_header_frame_deframer_unit failed");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    board.note_byte(b);
    bytes_sent++;
    if (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // hold the sender until every owed word has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    while (board.awaited.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [10:0] v);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    board.set_reg(idx, v);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // one frame, broken as err asks, with random control, address and payload
  task automatic send_frame(input frame_err_t err, input int count);
    logic [15:0] len;
    logic [15:0] ctl;
    logic [15:0] adr;
    logic [7:0]  sum;
    logic [7:0]  pay;
    int          lim;
    lim = int'((board.max_len < MAX_PAYLOAD) ? board.max_len : MAX_PAYLOAD);
    ctl = 16'($urandom);
    adr = 16'($urandom);
    len = 16'(count + 4);
    if (err == FE_SHORT) len = 16'($urandom_range(0, 3));
    if (err == FE_LONG)
      len = $urandom_range(1) ? 16'(lim + 5) : 16'($urandom_range(lim + 5, 65535));
    send_byte(HDR_BYTE);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    if (err == FE_SHORT || err == FE_LONG) return;
    if (err == FE_HDR2) begin
      pay = 8'($urandom);
      if (pay == HDR_BYTE) pay = ~pay;
      send_byte(pay);
      return;
    end
    send_byte(HDR_BYTE);
    send_byte(ctl[15:8]);
    send_byte(ctl[7:0]);
    send_byte(adr[15:8]);
    send_byte(adr[7:0]);
    sum = ctl[15:8] + ctl[7:0] + adr[15:8] + adr[7:0];
    for (int i = 0; i < count; i++) begin
      pay = 8'($urandom);
      sum += pay;
      send_byte(pay);
      // now and then stall the sender mid-frame until the output is empty
      if (i == count / 2 && $urandom_range(29) == 0) drain_results();
    end
    if (err == FE_CSUM || (err == FE_END && $urandom_range(1)))
      send_byte(~sum ^ 8'($urandom_range(1, 255)));
    else
      send_byte(~sum);
    if (err == FE_END) begin
      pay = 8'($urandom);
      if (pay == END_BYTE) pay = ~pay;
      send_byte(pay);
    end else begin
      send_byte(END_BYTE);
    end
  endtask

  // mostly well-formed frames, some broken ones and line noise
  task automatic random_traffic(input int n_bytes, input int max_count);
    int stop;
    int pick;
    int lim;
    int cap;
    int count;
    logic [7:0] junk;
    stop = bytes_sent + n_bytes;
    while (bytes_sent < stop) begin
      lim = int'((board.max_len < MAX_PAYLOAD) ? board.max_len : MAX_PAYLOAD);
      cap = (lim < max_count) ? lim : max_count;
      count = ($urandom_range(7) == 0) ? cap : $urandom_range(0, cap);
      pick = $urandom_range(99);
      if (pick < 60) send_frame(FE_NONE, count);
      else if (pick < 68) send_frame(FE_CSUM, count);
      else if (pick < 76) send_frame(FE_END, count);
      else if (pick < 82) send_frame(FE_SHORT, count);
      else if (pick < 88) send_frame(FE_LONG, count);
      else if (pick < 94) send_frame(FE_HDR2, count);
      else begin
        repeat ($urandom_range(1, 3)) begin
          junk = 8'($urandom);
          if (junk == HDR_BYTE && $urandom_range(9) != 0) junk = ~junk;
          send_byte(junk);
        end
      end
    end
  endtask

  initial begin
    board = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: junk while hunting, a good one-byte frame, bad length, bad header, raw bytes
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(HDR_BYTE);
    send_byte(8'h00);
    send_byte(8'h05);
    send_byte(HDR_BYTE);
    send_byte(8'h12);
    send_byte(8'h34);
    send_byte(8'hAB);
    send_byte(8'hCD);
    send_byte(8'hFF);
    drain_results();
    send_byte(8'h42);
    send_byte(END_BYTE);
    send_byte(HDR_BYTE);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(HDR_BYTE);
    send_byte(8'h00);
    send_byte(8'h04);
    send_byte(8'h00);
    drain_results();
    write_reg(REG_PARSE_ENABLE, 11'd0);
    send_byte(HDR_BYTE);
    send_byte(8'hFF);
    drain_results();
    write_reg(REG_PARSE_ENABLE, 11'd1);

    // default limit
    random_traffic(90, 12);
    drain_results();

    // no payload allowed
    write_reg(REG_MAX_PAYLOAD, 11'd0);
    random_traffic(60, 12);
    drain_results();

    // small limits, frames often sized right at the limit
    write_reg(REG_MAX_PAYLOAD, 11'($urandom_range(1, 20)));
    random_traffic(45, 20);
    drain_results();
    write_reg(REG_MAX_PAYLOAD, 11'($urandom_range(1, 20)));
    random_traffic(45, 20);
    drain_results();

    // passthrough
    write_reg(REG_PARSE_ENABLE, 11'd0);
    repeat (60) send_byte(8'($urandom));
    drain_results();

    // full limit, a long stretch with no idling and one longer frame
    write_reg(REG_PARSE_ENABLE, 11'd1);
    write_reg(REG_MAX_PAYLOAD, MAX_PAYLOAD);
    idle_on = 1'b0;
    send_frame(FE_NONE, 96);
    send_frame(FE_LONG, 0);
    random_traffic(55, 12);
    idle_on = 1'b1;
    random_traffic(55, 12);

    drain_results();
    repeat (10) @(posedge clk);
    if (board.errors == 0 && board.awaited.size() == 0)
      $display("tb_dual_header_frame_deframer_unit passed");
    else
      $display("tb_dual_header_frame_deframer_unit failed");
    $finish;
  end

endmodule
